// ----- hw/rtl/rvpc_pkg.sv -----
// Shared types and constants of the rotary valve position controller.
// No dependencies; imported by every RTL module of the block but rvpc_checker.
package rvpc_pkg;

	// Event kinds carried in the input beat's tuser
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_PULSE  = 2'd1,
		OP_TARGET = 2'd2,
		OP_CALIB  = 2'd3
	} rvpc_op_t;

	// Configuration register indexes
	localparam logic [2:0] REG_TOLERANCE = 3'd0;
	localparam logic [2:0] REG_STALL     = 3'd1;
	localparam logic [2:0] REG_CENTER_1  = 3'd2;
	localparam logic [2:0] REG_CENTER_2  = 3'd3;
	localparam logic [2:0] REG_CENTER_3  = 3'd4;
	localparam logic [2:0] REG_CENTER_4  = 3'd5;
	localparam logic [2:0] REG_CENTER_5  = 3'd6;

	localparam int NUM_POS    = 5;
	localparam int CENTER_W   = 12;
	localparam int CFG_DATA_W = 12;

	localparam logic [2:0] POS_NONE = 3'd0;
	localparam logic [2:0] POS_ONE  = 3'd1;
	localparam logic [2:0] POS_FIVE = 3'd5;

	// Drive line codes: bit 0 clockwise, bit 1 counterclockwise
	localparam logic [1:0] DRIVE_STOP = 2'b00;
	localparam logic [1:0] DRIVE_FWD  = 2'b01;
	localparam logic [1:0] DRIVE_REV  = 2'b10;

	localparam logic [7:0] TOL_RESET   = 8'd10;
	localparam logic [7:0] STALL_RESET = 8'd20;
	localparam logic [CENTER_W-1:0] CENTER_RESET [NUM_POS] = '{
		12'd0, 12'd240, 12'd450, 12'd670, 12'd950
	};

	typedef logic [CENTER_W-1:0] rvpc_center_t;

	typedef struct packed {
		logic [7:0]                 tolerance;
		logic [7:0]                 stall;
		rvpc_center_t [NUM_POS-1:0] centers;   // centers[0] is position one
	} rvpc_cfg_t;

	typedef struct packed {
		logic        drive_forward;
		logic        drive_reverse;
		logic [2:0]  position_index;
		logic [15:0] pulse_total;
		logic        calibrating;
		logic [2:0]  active_target;
		logic        status;
	} rvpc_result_t;

endpackage

// ----- hw/rtl/rvpc_cfg_regs.sv -----
// Configuration register file of the rotary valve position controller.
// Depends on rvpc_pkg for register indexes, reset values and rvpc_cfg_t.
module rvpc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [rvpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output rvpc_pkg::rvpc_cfg_t          cfg
);
	import rvpc_pkg::*;

	rvpc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance <= TOL_RESET;
			cfg_q.stall     <= STALL_RESET;
			for (int i = 0; i < NUM_POS; i++) begin
				cfg_q.centers[i] <= CENTER_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOLERANCE: cfg_q.tolerance  <= cfg_data[7:0];
				REG_STALL:     cfg_q.stall      <= cfg_data[7:0];
				REG_CENTER_1:  cfg_q.centers[0] <= cfg_data;
				REG_CENTER_2:  cfg_q.centers[1] <= cfg_data;
				REG_CENTER_3:  cfg_q.centers[2] <= cfg_data;
				REG_CENTER_4:  cfg_q.centers[3] <= cfg_data;
				REG_CENTER_5:  cfg_q.centers[4] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rvpc_core.sv -----
// Controller state and per-event update logic of the rotary valve controller.
// Depends on rvpc_pkg; fed by the input stage and config regs in the top level.
module rvpc_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  rvpc_pkg::rvpc_op_t     op,
	input  logic [2:0]             target_value,
	input  rvpc_pkg::rvpc_cfg_t    cfg,
	output rvpc_pkg::rvpc_result_t result
);
	import rvpc_pkg::*;

	localparam int CW = COUNT_WIDTH;
	// Difference width: holds count minus a 12-bit unsigned centre
	localparam int DW = ((CW > CENTER_W) ? CW : CENTER_W + 1) + 1;
	localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW-1:0] count_q, count_d;
	logic signed [CW-1:0] last_q, last_d;
	logic                 cw_q, cw_d;
	logic                 calib_q, calib_d;
	logic [2:0]           target_q, target_d;
	logic [2:0]           nearest_q, nearest_d;
	logic [7:0]           idle_q, idle_d;
	logic [1:0]           drive_q, drive_d;
	logic                 status_d;

	logic signed [DW-1:0] cnt_ext;
	logic signed [DW-1:0] cen_ext  [NUM_POS];
	logic [DW-1:0]        cen_dist [NUM_POS];
	logic [2:0]           best_pos;
	logic [DW-1:0]        best_dist;

	logic                 cnt_changed;
	logic [7:0]           idle_inc;
	logic                 stall_hit;
	logic signed [DW-1:0] tgt_cen;
	logic signed [DW-1:0] tgt_err;
	logic [DW-1:0]        tgt_abs;
	logic [CENTER_W-1:0]  end_cen;
	logic signed [CW-1:0] end_cnt;
	logic signed [31:0]   count_wide;

	// Distances from the count to every centre
	always_comb begin
		cnt_ext = DW'(count_q);
		for (int i = 0; i < NUM_POS; i++) begin
			cen_ext[i]  = signed'(DW'(cfg.centers[i]));
			cen_dist[i] = (cnt_ext >= cen_ext[i]) ? DW'(cnt_ext - cen_ext[i])
			                                      : DW'(cen_ext[i] - cnt_ext);
		end
	end

	// Nearest centre, ties kept by the lower position
	always_comb begin
		best_pos  = POS_ONE;
		best_dist = cen_dist[0];
		for (int i = 1; i < NUM_POS; i++) begin
			if (cen_dist[i] < best_dist) begin
				best_dist = cen_dist[i];
				best_pos  = 3'(i + 1);
			end
		end
	end

	// Stall tracking and target error
	always_comb begin
		cnt_changed = (count_q != last_q);
		idle_inc    = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
		stall_hit   = !cnt_changed && (idle_inc >= cfg.stall);
		case (target_q)
			3'd1:    tgt_cen = cen_ext[0];
			3'd2:    tgt_cen = cen_ext[1];
			3'd3:    tgt_cen = cen_ext[2];
			3'd4:    tgt_cen = cen_ext[3];
			default: tgt_cen = cen_ext[4];
		endcase
		tgt_err = tgt_cen - cnt_ext;
		tgt_abs = (tgt_err < 0) ? DW'(-tgt_err) : DW'(tgt_err);
		end_cen = (target_q == POS_ONE) ? cfg.centers[0] : cfg.centers[4];
		end_cnt = (DW'(end_cen) > DW'(CNT_MAX)) ? CNT_MAX : CW'(end_cen);
	end

	// Next state
	always_comb begin
		count_d   = count_q;
		last_d    = last_q;
		cw_d      = cw_q;
		calib_d   = calib_q;
		target_d  = target_q;
		nearest_d = nearest_q;
		idle_d    = idle_q;
		drive_d   = drive_q;
		status_d  = 1'b0;
		unique case (op)
			OP_TICK: begin
				nearest_d = best_pos;
				if (calib_q) begin
					if (cnt_changed) begin
						last_d = count_q;
						idle_d = 8'd0;
					end else begin
						idle_d = idle_inc;
					end
					if (stall_hit) begin
						drive_d = DRIVE_STOP;
						count_d = '0;
						calib_d = 1'b0;
					end
				end else if (target_q == POS_NONE || target_q > POS_FIVE) begin
					target_d = POS_NONE;
					drive_d  = DRIVE_STOP;
					last_d   = count_q;
					idle_d   = 8'd0;
				end else if (tgt_abs > DW'(cfg.tolerance)) begin
					if (cnt_changed) begin
						last_d = count_q;
						idle_d = 8'd0;
					end else begin
						idle_d = idle_inc;
					end
					if (stall_hit) begin
						// End stop reached: snap the count at either end position
						drive_d = DRIVE_STOP;
						if (target_q == POS_ONE || target_q == POS_FIVE) begin
							count_d = end_cnt;
						end
						target_d = POS_NONE;
					end else if (tgt_err > 0) begin
						cw_d    = 1'b1;
						drive_d = DRIVE_FWD;
					end else begin
						cw_d    = 1'b0;
						drive_d = DRIVE_REV;
					end
				end else begin
					drive_d = DRIVE_STOP;
					last_d  = count_q;
					idle_d  = 8'd0;
				end
			end
			OP_PULSE: begin
				if (cw_q) begin
					count_d = (count_q == CNT_MAX) ? count_q : count_q + CW'(1);
				end else begin
					count_d = (count_q == CNT_MIN) ? count_q : count_q - CW'(1);
				end
			end
			OP_TARGET: begin
				if (calib_q || target_value > POS_FIVE) begin
					status_d = 1'b1;
				end else begin
					target_d = target_value;
				end
			end
			OP_CALIB: begin
				calib_d  = 1'b1;
				target_d = POS_NONE;
				cw_d     = 1'b0;
				drive_d  = DRIVE_REV;
				idle_d   = 8'd0;
				last_d   = count_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			last_q    <= '0;
			cw_q      <= 1'b1;
			calib_q   <= 1'b0;
			target_q  <= POS_NONE;
			nearest_q <= POS_NONE;
			idle_q    <= 8'd0;
			drive_q   <= DRIVE_STOP;
		end else if (step) begin
			count_q   <= count_d;
			last_q    <= last_d;
			cw_q      <= cw_d;
			calib_q   <= calib_d;
			target_q  <= target_d;
			nearest_q <= nearest_d;
			idle_q    <= idle_d;
			drive_q   <= drive_d;
		end
	end

	assign count_wide = 32'(count_d);

	always_comb begin
		result.drive_forward  = drive_d[0];
		result.drive_reverse  = drive_d[1];
		result.position_index = nearest_d;
		result.pulse_total    = count_wide[15:0];
		result.calibrating    = calib_d;
		result.active_target  = target_d;
		result.status         = status_d;
	end

endmodule

// ----- hw/rtl/rotary_valve_position_controller_top.sv -----
// Top level of the rotary valve position controller: stream ports, input and
// result stages. Depends on rvpc_pkg, rvpc_cfg_regs and rvpc_core.
//
// The controller takes one event beat per cycle while results are taken
// (control tick, encoder pulse, set-target request or calibration start) and
// returns exactly one result beat for each, in order. An event lands in an
// input register, the controller state is updated from it in a single pass of
// logic, and the result is held in an output register. The input keeps
// accepting while a result waits, as long as the output register drains or
// is empty. Configuration writes go through the cfg channel (always ready)
// and must only be issued with no events in flight. Reset brings the control,
// configuration and state registers to their documented defaults at once
// (the input and result data registers have none); no clearing pass is
// needed. COUNT_WIDTH sets the encoder count width (12 to 32); pulse_total
// shows its low 16 bits, sign-extended for narrower counts.
module rotary_valve_position_controller_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Event input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [2:0] target_value, [7:3] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	// Result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [0] drive_forward, [1] drive_reverse,
	                                    // [4:2] position_index, [20:5] pulse_total,
	                                    // [21] calibrating, [24:22] active_target,
	                                    // [31:25] zero
	output logic [0:0]  m_axis_tuser,   // [0] status
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [rvpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rvpc_pkg::*;

	rvpc_cfg_t    cfg;
	rvpc_result_t res_comb;

	logic         valid_s1;
	rvpc_op_t     op_s1;
	logic [2:0]   tv_s1;
	logic         valid_s2;
	rvpc_result_t res_s2;
	logic         advance;

	// Move the event out of the input register whenever the result slot frees
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	rvpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rvpc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.op           (op_s1),
		.target_value (tv_s1),
		.cfg          (cfg),
		.result       (res_comb)
	);

	// Input stage: hold the beat until the core consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= rvpc_op_t'(s_axis_tuser);
			tv_s1 <= s_axis_tdata[2:0];
		end
	end

	// Result stage: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0,
	                        res_s2.active_target,
	                        res_s2.calibrating,
	                        res_s2.pulse_total,
	                        res_s2.position_index,
	                        res_s2.drive_reverse,
	                        res_s2.drive_forward};
	assign m_axis_tuser  = res_s2.status;

endmodule

// ----- hw/rtl/rvpc_checker.sv -----
// Port-level checks of the rotary valve position controller result stream.
// Bound to rotary_valve_position_controller_top; needs no package.
module rvpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// Never drive both motor lines
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("both drive lines active");

	// Calibration only drives counterclockwise and holds no target
	a_calib: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[21] |->
			!m_axis_tdata[0] && (m_axis_tdata[24:22] == 3'd0))
		else $error("calibration with forward drive or target");

	// Position and target stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:2] <= 3'd5) && (m_axis_tdata[24:22] <= 3'd5))
		else $error("position or target out of range");

endmodule

bind rotary_valve_position_controller_top rvpc_checker u_rvpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- dv/rotary_valve_position_controller_top_tb.sv -----
// Self-checking testbench for rotary_valve_position_controller_top: event and result
// streams, config writes, and a built-in predictor of the valve controller.
// Depends on rvpc_pkg and the RTL of the block only.
module rotary_valve_position_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvpc_pkg::*;

	localparam int     COUNT_WIDTH = 16;
	localparam longint COUNT_MAX   = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
	localparam longint COUNT_MIN   = -(longint'(1) << (COUNT_WIDTH - 1));
	localparam int     QUIET_LIMIT = 3000;  // cycles with no beat on any channel
	localparam int     HOLD_CYCLES = 150;   // long receiver hold-off
	localparam int     PRINT_LIMIT = 20;

	typedef struct {
		rvpc_op_t   op;
		logic [2:0] tv;
	} valve_event_t;

	typedef struct {
		logic [2:0]            index;
		logic [CFG_DATA_W-1:0] value;
	} reg_write_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rotary_valve_position_controller_top #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus and expectation stores
	valve_event_t pending_events[$];
	reg_write_t   pending_writes[$];
	rvpc_result_t expected_results[$];

	bit send_idle_on = 1'b0;
	bit recv_idle_on = 1'b0;
	bit hold_request = 1'b0;

	int events_queued;
	int beats_in;
	int results_seen;
	int writes_done;
	int mismatches;
	int op_tally [4];
	int rejects;
	int stalls;

	// Predictor copy of the configuration
	int tolerance_now;
	int stall_now;
	int centers_now [1:5];

	// Predictor copy of the controller state
	longint     pred_count;
	bit         pred_cw;
	bit         pred_cal;
	logic [2:0] pred_target;
	logic [2:0] pred_nearest;
	longint     pred_last;
	int         pred_idle;
	logic [1:0] pred_drive;

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint saturate_count(longint v);
		if (v > COUNT_MAX)
			return COUNT_MAX;
		if (v < COUNT_MIN)
			return COUNT_MIN;
		return v;
	endfunction

	// Record a moving count or advance the idle tick count; true once it reaches the stall limit
	function automatic bit stall_seen();
		if (pred_count != pred_last) begin
			pred_last = pred_count;
			pred_idle = 0;
			return 1'b0;
		end
		if (pred_idle < 255)
			pred_idle++;
		return pred_idle >= stall_now;
	endfunction

	function automatic void hold_still();
		pred_drive = DRIVE_STOP;
		pred_last  = pred_count;
		pred_idle  = 0;
	endfunction

	// Advance the predicted controller by one event and form its result beat
	task automatic predict_valve(input rvpc_op_t op, input logic [2:0] tv,
			output rvpc_result_t r);
		logic   rejected;
		int     best;
		longint best_err;
		longint e;
		longint err;
		rejected = 1'b0;
		op_tally[op]++;
		case (op)
			OP_TICK: begin
				best     = 1;
				best_err = magnitude(pred_count - longint'(centers_now[1]));
				for (int p = 2; p <= NUM_POS; p++) begin
					e = magnitude(pred_count - longint'(centers_now[p]));
					if (e < best_err) begin
						best_err = e;
						best     = p;
					end
				end
				pred_nearest = best[2:0];
				if (pred_cal) begin
					if (stall_seen()) begin
						pred_drive = DRIVE_STOP;
						pred_count = 0;
						pred_cal   = 1'b0;
						stalls++;
					end
				end else if (pred_target == POS_NONE || pred_target > POS_FIVE) begin
					pred_target = POS_NONE;
					hold_still();
				end else begin
					err = longint'(centers_now[pred_target]) - pred_count;
					if (magnitude(err) > longint'(tolerance_now)) begin
						if (stall_seen()) begin
							// Stalled against an end stop: trust the end centre
							pred_drive = DRIVE_STOP;
							if (pred_target == POS_ONE)
								pred_count = saturate_count(longint'(centers_now[1]));
							if (pred_target == POS_FIVE)
								pred_count = saturate_count(longint'(centers_now[5]));
							pred_target = POS_NONE;
							stalls++;
						end else if (err > 0) begin
							pred_cw    = 1'b1;
							pred_drive = DRIVE_FWD;
						end else begin
							pred_cw    = 1'b0;
							pred_drive = DRIVE_REV;
						end
					end else begin
						hold_still();
					end
				end
			end
			OP_PULSE: pred_count = saturate_count(pred_count + (pred_cw ? 1 : -1));
			OP_TARGET: begin
				if (pred_cal || tv > POS_FIVE) begin
					rejected = 1'b1;
					rejects++;
				end else begin
					pred_target = tv;
				end
			end
			OP_CALIB: begin
				pred_cal    = 1'b1;
				pred_target = POS_NONE;
				pred_cw     = 1'b0;
				pred_drive  = DRIVE_REV;
				pred_idle   = 0;
				pred_last   = pred_count;
			end
		endcase
		r.drive_forward  = pred_drive[0];
		r.drive_reverse  = pred_drive[1];
		r.position_index = pred_nearest;
		r.pulse_total    = pred_count[15:0];
		r.calibrating    = pred_cal;
		r.active_target  = pred_target;
		r.status         = rejected;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
				$realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	// Event driver: predict each accepted beat, then offer the next one
	always @(posedge clk) begin : event_driver
		valve_event_t ev;
		rvpc_result_t want;
		int           gap_left;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_valve(rvpc_op_t'(s_axis_tuser), s_axis_tdata[2:0], want);
				expected_results.push_back(want);
				beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (send_idle_on && pending_events.size() != 0
						&& $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 5);
					s_axis_tvalid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					ev = pending_events.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= ev.op;
					s_axis_tdata  <= {5'd0, ev.tv};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Config driver: mirror each accepted write into the predictor
	always @(posedge clk) begin : config_driver
		reg_write_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOLERANCE: tolerance_now = int'(cfg_data[7:0]);
					REG_STALL:     stall_now = int'(cfg_data[7:0]);
					default:       centers_now[cfg_index - REG_CENTER_1 + 1] = int'(cfg_data);
				endcase
				writes_done++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					w = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.index;
					cfg_data  <= w.value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each beat with the oldest expectation, then drive ready
	always @(posedge clk) begin : result_monitor
		rvpc_result_t got;
		rvpc_result_t want;
		int           stall_left;
		int           hold_left;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.drive_forward  = m_axis_tdata[0];
				got.drive_reverse  = m_axis_tdata[1];
				got.position_index = m_axis_tdata[4:2];
				got.pulse_total    = m_axis_tdata[20:5];
				got.calibrating    = m_axis_tdata[21];
				got.active_target  = m_axis_tdata[24:22];
				got.status         = m_axis_tuser[0];
				if (expected_results.size() == 0) begin
					report_mismatch("arrived with nothing expected", m_axis_tdata, 0);
				end else begin
					want = expected_results.pop_front();
					if (got.drive_forward !== want.drive_forward)
						report_mismatch("drive_forward", got.drive_forward, want.drive_forward);
					if (got.drive_reverse !== want.drive_reverse)
						report_mismatch("drive_reverse", got.drive_reverse, want.drive_reverse);
					if (got.position_index !== want.position_index)
						report_mismatch("position_index", got.position_index,
							want.position_index);
					if (got.pulse_total !== want.pulse_total)
						report_mismatch("pulse_total", got.pulse_total, want.pulse_total);
					if (got.calibrating !== want.calibrating)
						report_mismatch("calibrating", got.calibrating, want.calibrating);
					if (got.active_target !== want.active_target)
						report_mismatch("active_target", got.active_target, want.active_target);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
				end
				results_seen++;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no channel moves a beat for too long
	always @(posedge clk) begin : watchdog
		int quiet;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: %0d cycles without a beat, %0d results outstanding",
					quiet, expected_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_event(input rvpc_op_t op, input logic [2:0] tv);
		valve_event_t ev;
		ev.op = op;
		ev.tv = tv;
		pending_events.push_back(ev);
		events_queued++;
	endtask

	task automatic push_pulses(input int n);
		repeat (n) push_event(OP_PULSE, 3'($urandom_range(0, 7)));
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_event(OP_TICK, 3'($urandom_range(0, 7)));
	endtask

	task automatic queue_write(input logic [2:0] index, input int value);
		reg_write_t w;
		w.index = index;
		w.value = value[CFG_DATA_W-1:0];
		pending_writes.push_back(w);
	endtask

	// Hold until every queued beat is through and every result is back
	task automatic wait_quiet();
		while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0
				|| pending_writes.size() != 0 || cfg_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(input int tol, input int stall, input int c1, input int c2,
			input int c3, input int c4, input int c5);
		wait_quiet();
		queue_write(REG_TOLERANCE, tol);
		queue_write(REG_STALL, stall);
		queue_write(REG_CENTER_1, c1);
		queue_write(REG_CENTER_2, c2);
		queue_write(REG_CENTER_3, c3);
		queue_write(REG_CENTER_4, c4);
		queue_write(REG_CENTER_5, c5);
		wait_quiet();
	endtask

	// Mostly target moves and calibration runs with random content, some raw noise
	task automatic random_events(input int budget, input int step_max, input int run_max);
		int         start;
		int         kind;
		logic [2:0] tv;
		start = events_queued;
		while (events_queued - start < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				tv = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
				                                 : 3'($urandom_range(1, 5));
				push_event(OP_TARGET, tv);
				repeat ($urandom_range(3, 15)) begin
					push_pulses($urandom_range(0, step_max));
					push_event(OP_TICK, 3'($urandom_range(0, 7)));
				end
				if ($urandom_range(0, 2) == 0)
					push_ticks($urandom_range(1, run_max));
			end else if (kind < 75) begin
				push_event(OP_CALIB, 3'($urandom_range(0, 7)));
				if ($urandom_range(0, 1) == 0)
					push_event(OP_TARGET, 3'($urandom_range(0, 7)));
				repeat ($urandom_range(0, 4)) begin
					push_pulses($urandom_range(0, step_max));
					push_event(OP_TICK, 3'($urandom_range(0, 7)));
				end
				push_ticks($urandom_range(1, run_max));
			end else begin
				repeat (8) push_event(rvpc_op_t'(2'($urandom_range(0, 3))),
					3'($urandom_range(0, 7)));
			end
		end
	endtask

	initial begin : stimulus
		tolerance_now  = int'(TOL_RESET);
		stall_now      = int'(STALL_RESET);
		for (int p = 1; p <= NUM_POS; p++)
			centers_now[p] = int'(CENTER_RESET[p - 1]);
		pred_count   = 0;
		pred_cw      = 1'b1;
		pred_cal     = 1'b0;
		pred_target  = POS_NONE;
		pred_nearest = POS_NONE;
		pred_last    = 0;
		pred_idle    = 0;
		pred_drive   = DRIVE_STOP;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: rejected and accepted targets, calibration restart, stall, end corrections
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		push_event(OP_TICK, 3'd0);
		push_event(OP_TARGET, 3'd7);
		push_event(OP_TARGET, 3'd6);
		push_event(OP_TARGET, POS_NONE);
		push_event(OP_TARGET, 3'd2);
		push_event(OP_TICK, 3'd0);
		push_pulses(3);
		push_event(OP_TICK, 3'd0);
		push_event(OP_CALIB, 3'd0);
		push_event(OP_TARGET, 3'd3);
		push_event(OP_PULSE, 3'd0);
		push_event(OP_CALIB, 3'd0);
		push_event(OP_TICK, 3'd0);
		wait_quiet();
		// A stall limit of zero: the first unchanged tick counts as a stall
		queue_write(REG_STALL, 0);
		wait_quiet();
		push_event(OP_TICK, 3'd0);
		push_event(OP_TARGET, POS_FIVE);
		push_ticks(2);
		push_event(OP_TARGET, POS_FIVE);
		push_event(OP_TICK, 3'd0);
		push_event(OP_TARGET, POS_ONE);
		push_event(OP_TICK, 3'd0);
		push_event(OP_PULSE, 3'd0);

		// All centres at the top of their range, zero tolerance, zero stall limit
		write_config(0, 0, 4095, 4095, 4095, 4095, 4095);
		random_events(40, 20, 4);

		// Tight centres so that ties and small moves come up often
		write_config(2, 3, 0, 10, 20, 30, 40);
		// Long receiver hold-off while the sender keeps offering; then the sender waits
		send_idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (40) push_event(rvpc_op_t'(2'($urandom_range(0, 3))), 3'($urandom_range(0, 7)));
		wait_quiet();
		send_idle_on = 1'b1;
		random_events(80, 8, 6);

		// Widest tolerance and a long stall limit, during calibration and toward position five
		write_config(255, 40, 0, 300, 600, 900, 1200);
		push_event(OP_CALIB, 3'd0);
		push_ticks(43);
		push_event(OP_TARGET, POS_FIVE);
		push_ticks(45);
		random_events(40, 25, 10);

		begin : random_settings
			int st;
			st = $urandom_range(1, 10);
			write_config($urandom_range(0, 20), st, $urandom_range(0, 300),
				$urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 300),
				$urandom_range(0, 300));
			random_events(60, 15, st + 3);

			// Last part: no idling on either side
			st = $urandom_range(1, 6);
			write_config($urandom_range(0, 12), st, $urandom_range(0, 100),
				$urandom_range(50, 200), $urandom_range(100, 300), $urandom_range(200, 400),
				$urandom_range(300, 500));
			wait_quiet();
			send_idle_on = 1'b0;
			recv_idle_on = 1'b0;
			random_events(60, 15, st + 3);
		end

		wait_quiet();
		repeat (6) @(negedge clk);

		$display("Covered %0d events: %0d ticks, %0d pulses, %0d target requests (%0d rejected),",
			beats_in, op_tally[OP_TICK], op_tally[OP_PULSE], op_tally[OP_TARGET], rejects);
		$display("%0d calibration starts, %0d stalls, %0d register writes; %0d results, %0d bad",
			op_tally[OP_CALIB], stalls, writes_done, results_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- rotary_valve_position_controller_top.f -----
hw/rtl/rvpc_pkg.sv
hw/rtl/rvpc_cfg_regs.sv
hw/rtl/rvpc_core.sv
hw/rtl/rotary_valve_position_controller_top.sv
hw/rtl/rvpc_checker.sv
dv/rotary_valve_position_controller_top_tb.sv
